[sv/button_conditioner_press_events_assert.svh]
// Assertion macros for the button conditioner checker.
`ifndef BUTTON_CONDITIONER_PRESS_EVENTS_ASSERT_SVH
`define BUTTON_CONDITIONER_PRESS_EVENTS_ASSERT_SVH

// Check a property every clock edge outside reset.
`define BCPE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("bcpe assertion failed");

// Check that an antecedent implies a consequent in the same cycle.
`define BCPE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bcpe implication failed");

// Check that an antecedent implies a consequent in the next cycle.
`define BCPE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bcpe next-cycle check failed");

`endif

[sv/bcpe_pkg.sv]
// Package with types, constants and helpers for the button conditioner.
`timescale 1ns / 1ps
package bcpe_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam int unsigned IDX_W       = 2;

  localparam logic [IDX_W-1:0] CFG_HOLD_TICKS    = 2'd0;
  localparam logic [IDX_W-1:0] CFG_PRESS_TIME_MS = 2'd1;
  localparam logic [IDX_W-1:0] CFG_REPEAT_PERIOD = 2'd2;

  localparam logic [CFG_W-1:0] HOLD_RESET       = CFG_W'(500);
  localparam logic [CFG_W-1:0] PRESS_TIME_RESET = CFG_W'(1000);
  localparam logic [CFG_W-1:0] REPEAT_RESET     = CFG_W'(100);

  localparam logic [1:0] PHASE_MAX = 2'd3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_SHORT = 2'd1;
  localparam logic [1:0] KIND_LONG  = 2'd2;

  typedef struct packed {
    logic raw_level;
    logic ms_strobe;
  } in_t;

  typedef struct packed {
    logic       pressed;
    logic       press_pulse;
    logic       release_pulse;
    logic       edge_pulse;
    logic       toggle_on_press;
    logic       toggle_on_release;
    logic       timed_pulse;
    logic [1:0] press_kind;
    logic       repeat_pulse;
  } out_t;

  typedef struct packed {
    logic [CFG_W-1:0] hold_ticks;
    logic [CFG_W-1:0] press_time_ms;
    logic [CFG_W-1:0] repeat_period;
  } cfg_t;

  typedef struct packed {
    logic                   held;
    logic [COUNT_WIDTH-1:0] stretch_count;
    logic [1:0]             press_phase;
    logic                   press_toggle;
    logic                   release_toggle;
    logic [COUNT_WIDTH-1:0] since_press_ms;
    logic                   timed_armed;
    logic                   kind_armed;
    logic [COUNT_WIDTH-1:0] repeat_count;
  } state_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

endpackage

[sv/bcpe_step.sv]
// Per-tick update of debounce, pulses, timer, press code and auto-repeat.
`timescale 1ns / 1ps
module bcpe_step (
  input  bcpe_pkg::cfg_t   cfg_i,
  input  bcpe_pkg::state_t state_i,
  input  bcpe_pkg::in_t    in_i,
  output bcpe_pkg::state_t state_o,
  output bcpe_pkg::out_t   out_o
);

  logic                             held1, held2;
  logic [bcpe_pkg::COUNT_WIDTH-1:0] sc1, sc2;
  logic [bcpe_pkg::CMP_W-1:0]       sc_x, hold_x, ptime_x, since_x, rc_x, period_x;
  logic [1:0]                       phase1;
  logic                             pp, rp, over, ta1, ka1;
  logic [bcpe_pkg::COUNT_WIDTH-1:0] since1, rc1;
  logic [1:0]                       kind;

  always_comb begin
    held1 = state_i.held | ~in_i.raw_level;
    sc1   = in_i.raw_level ? state_i.stretch_count : '0;
    sc2   = held1 ? bcpe_pkg::sat_inc(sc1) : sc1;

    sc_x     = bcpe_pkg::CMP_W'(sc2);
    hold_x   = bcpe_pkg::CMP_W'(cfg_i.hold_ticks);
    ptime_x  = bcpe_pkg::CMP_W'(cfg_i.press_time_ms);
    period_x = bcpe_pkg::CMP_W'(cfg_i.repeat_period);

    held2 = held1 && !(sc_x >= hold_x);

    phase1 = state_i.press_phase;
    if (held2 && state_i.press_phase < bcpe_pkg::PHASE_MAX) begin
      phase1 = state_i.press_phase + 2'd1;
    end
    pp = (phase1 == 2'd1);
    rp = held2 && (hold_x != '0) && (sc_x == hold_x - bcpe_pkg::CMP_W'(1));

    if (pp) begin
      since1 = '0;
    end else if (in_i.ms_strobe) begin
      since1 = bcpe_pkg::sat_inc(state_i.since_press_ms);
    end else begin
      since1 = state_i.since_press_ms;
    end
    since_x = bcpe_pkg::CMP_W'(since1);
    over    = since_x > ptime_x;
    ta1     = pp | state_i.timed_armed;
    ka1     = pp | state_i.kind_armed;

    kind = bcpe_pkg::KIND_NONE;
    if (ka1) begin
      if (over) begin
        kind = bcpe_pkg::KIND_LONG;
      end else if (!held2) begin
        kind = bcpe_pkg::KIND_SHORT;
      end
    end

    rc1  = bcpe_pkg::sat_inc(state_i.repeat_count);
    rc_x = bcpe_pkg::CMP_W'(rc1);

    state_o.held           = held2;
    state_o.stretch_count  = sc2;
    state_o.press_phase    = rp ? 2'd0 : phase1;
    state_o.press_toggle   = state_i.press_toggle ^ pp;
    state_o.release_toggle = state_i.release_toggle ^ rp;
    state_o.since_press_ms = since1;
    state_o.timed_armed    = ta1 & ~over;
    state_o.kind_armed     = ka1 & ~over & held2;
    state_o.repeat_count   = (held2 && !(rc_x >= period_x)) ? rc1 : '0;

    out_o.pressed           = held2;
    out_o.press_pulse       = pp;
    out_o.release_pulse     = rp;
    out_o.edge_pulse        = pp | rp;
    out_o.toggle_on_press   = state_o.press_toggle;
    out_o.toggle_on_release = state_o.release_toggle;
    out_o.timed_pulse       = ta1 & over;
    out_o.press_kind        = kind;
    out_o.repeat_pulse      = held2 && (rc1 == bcpe_pkg::COUNT_WIDTH'(1));
  end

endmodule

[sv/button_conditioner_press_events.sv]
// Top level of the pushbutton conditioner with debounce and press events.
//
//   channel | direction | payload            | handshake
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | bcpe_pkg::in_t     | in_valid_i / in_stall_o
//   out     | output    | bcpe_pkg::out_t    | out_valid_o / out_stall_i
//   cfg     | input     | 16-bit write data  | cfg_we_i, cfg_idx_i, no wait
//
// One transfer per cycle sustained while the output is not stalled; a sample
// is captured in the input register at its transfer, then in the result
// register when it advances, and transfers out from there.
// The per-tick update between the two registers sets the cycle time.
// Reset clears the pipeline valid bits and all conditioner state and loads
// the register defaults. An output stall holds the result register and
// backs up into the input register, then stalls the input.
`timescale 1ns / 1ps
module button_conditioner_press_events (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bcpe_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bcpe_pkg::out_t                   out_data_o,
  input  logic                             cfg_we_i,
  input  logic [bcpe_pkg::IDX_W-1:0]       cfg_idx_i,
  input  logic [bcpe_pkg::CFG_W-1:0]       cfg_wdata_i
);

  bcpe_pkg::cfg_t   cfg_q, cfg_d;
  bcpe_pkg::state_t state_q, state_d;
  bcpe_pkg::in_t    in_q;
  bcpe_pkg::out_t   out_q, res_d;
  logic             in_valid_q, out_valid_q;
  logic             advance;

  bcpe_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .in_i    (in_q),
    .state_o (state_d),
    .out_o   (res_d)
  );

  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcpe_pkg::CFG_HOLD_TICKS:    cfg_d.hold_ticks    = cfg_wdata_i;
        bcpe_pkg::CFG_PRESS_TIME_MS: cfg_d.press_time_ms = cfg_wdata_i;
        bcpe_pkg::CFG_REPEAT_PERIOD: cfg_d.repeat_period = cfg_wdata_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ticks    <= bcpe_pkg::HOLD_RESET;
      cfg_q.press_time_ms <= bcpe_pkg::PRESS_TIME_RESET;
      cfg_q.repeat_period <= bcpe_pkg::REPEAT_RESET;
      state_q             <= '0;
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

endmodule

[sv/bcpe_checker.sv]
// Port-level checker for the button conditioner, bound to the top level.
`timescale 1ns / 1ps
`include "button_conditioner_press_events_assert.svh"
module bcpe_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input bcpe_pkg::out_t out_data_o
);

  `BCPE_ASSERT_IMP(a_edge_is_or, clk_i, rst_ni, out_valid_o,
    out_data_o.edge_pulse == (out_data_o.press_pulse | out_data_o.release_pulse))
  `BCPE_ASSERT_IMP(a_kind_legal, clk_i, rst_ni, out_valid_o,
    (out_data_o.press_kind == bcpe_pkg::KIND_NONE) ||
    (out_data_o.press_kind == bcpe_pkg::KIND_SHORT) ||
    (out_data_o.press_kind == bcpe_pkg::KIND_LONG))
  `BCPE_ASSERT_IMP(a_repeat_held, clk_i, rst_ni, out_valid_o && out_data_o.repeat_pulse,
    out_data_o.pressed)
  `BCPE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o))

endmodule

bind button_conditioner_press_events bcpe_checker u_bcpe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
